FILE: hdl/rim_pkg.sv
// Shared types and constants for the run-length image mirror.
// No dependencies; imported by rim_front, rim_back and the top level.
package rim_pkg;

   localparam int LEN_W        = 19;
   localparam int CHAN_W       = 8;
   localparam int NUM_CHAN     = 3;
   localparam int COLOR_W      = NUM_CHAN * CHAN_W;
   localparam int WIDTH_REG_W  = 7;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_MODE    = CSR_IDX_W'(2);

   // Run queued between front end and row engine
   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [COLOR_W-1:0] color;
   } job_type;

   // Run produced by the row engine
   typedef struct packed {
      logic [LEN_W-1:0]   count;
      logic [COLOR_W-1:0] color;
      logic               last;
   } result_type;

endpackage

FILE: hdl/rim_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rim_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, data held while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/rim_fifo.sv
// Small synchronous FIFO with show-ahead read data.
// No dependencies; used for the run queue and the result queue.
module rim_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: hdl/rim_front.sv
// Front end: takes input runs, maps gray mode, drops empty runs, queues the rest.
// Depends on rim_pkg and rim_fifo.
module rim_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [rim_pkg::LEN_W-1:0]           run_length,
   input  logic [rim_pkg::CHAN_W-1:0]          red,
   input  logic [rim_pkg::CHAN_W-1:0]          green,
   input  logic [rim_pkg::CHAN_W-1:0]          blue,
   input  logic                                gray_mode,
   output logic                                job_valid,
   output rim_pkg::job_type                    job,
   input  logic                                job_pop
);

   import rim_pkg::*;

   localparam int JOB_DEPTH = 2;

   job_type                 job_new;
   logic                    job_keep;
   logic [$bits(job_type)-1:0] q_dout;
   logic                    q_empty;

   // Build the queued run; green and blue follow red in gray mode
   always_comb begin
      job_new.len = run_length;
      if (gray_mode) begin
         job_new.color = {red, red, red};
      end else begin
         job_new.color = {red, green, blue};
      end
   end

   // Drop zero-length runs at the door
   assign job_keep = push && (run_length != '0);

   rim_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (JOB_DEPTH)
   ) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .push    (job_keep),
      .wr_data (job_new),
      .full    (full),
      .pop     (job_pop),
      .rd_data (q_dout),
      .empty   (q_empty)
   );

   assign job_valid = !q_empty;
   assign job       = job_type'(q_dout);

endmodule

FILE: hdl/rim_back.sv
// Row engine: expands runs into the row RAM, reads full rows back mirrored and
// re-encodes them as runs. Depends on rim_pkg and rim_ram.
module rim_back #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rim_pkg::WIDTH_REG_W-1:0]     image_width,
   input  logic [rim_pkg::HEIGHT_REG_W-1:0]    image_height,
   input  logic                                job_valid,
   input  rim_pkg::job_type                    job,
   output logic                                job_pop,
   output logic                                res_push,
   output rim_pkg::result_type                 res,
   input  logic                                res_full
);

   import rim_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FILL   = 3'd1;
   localparam logic [2:0] ST_FLUSH  = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_ROWEND = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [WW-1:0]      fill_ff, fill_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [COLOR_W-1:0] pend_color_ff, pend_color_in;
   logic [LEN_W-1:0]   pend_len_ff, pend_len_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               done_ff, done_in;
   logic               dv_ff, dv_in;

   logic [WW-1:0]      w_eff;
   logic [HW-1:0]      h_eff;
   logic [WW-1:0]      fill_nx;
   logic [HW-1:0]      row_p1;
   logic               last_row;
   logic               stall;
   logic               ram_we, ram_re;
   logic [COLOR_W-1:0] ram_rdata;

   // Clamp the configured size into the supported range
   always_comb begin
      if (image_width == '0) begin
         w_eff = WW'(1);
      end else if (image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(image_width);
      end
      if (image_height == '0) begin
         h_eff = HW'(1);
      end else if (image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(image_height);
      end
   end

   assign fill_nx  = fill_ff + WW'(1);
   assign row_p1   = HW'(row_ff) + HW'(1);
   assign last_row = (row_p1 >= h_eff);
   assign stall    = res_full;

   // Every emitted run is the open run; only the row-end one closes the image
   assign res = '{count: pend_len_ff, color: pend_color_ff, last: (state_ff == ST_ROWEND)};

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      color_in      = color_ff;
      fill_in       = fill_ff;
      rd_idx_in     = rd_idx_ff;
      row_in        = row_ff;
      pend_color_in = pend_color_ff;
      pend_len_in   = pend_len_ff;
      pend_valid_in = pend_valid_ff;
      done_in       = done_ff;
      job_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      res_push      = 1'b0;

      // Merge one mirrored pixel into the open run
      if (dv_ff && !stall) begin
         if (pend_valid_ff && (ram_rdata == pend_color_ff)) begin
            pend_len_in = pend_len_ff + LEN_W'(1);
         end else begin
            res_push      = pend_valid_ff;
            pend_color_in = ram_rdata;
            pend_len_in   = LEN_W'(1);
            pend_valid_in = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Take the next run; drop it once the image is complete
            if (job_valid) begin
               job_pop = 1'b1;
               if (!done_ff) begin
                  len_in   = job.len;
                  color_in = job.color;
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            // Write one pixel; a full row starts the mirrored read
            ram_we = 1'b1;
            len_in = len_ff - LEN_W'(1);
            if (fill_nx >= w_eff) begin
               fill_in   = '0;
               rd_idx_in = AW'(w_eff - WW'(1));
               state_in  = ST_FLUSH;
            end else begin
               fill_in = fill_nx;
               if (len_ff == LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            // Read the row right to left
            if (!stall) begin
               ram_re = 1'b1;
               if (rd_idx_ff == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  rd_idx_in = rd_idx_ff - AW'(1);
               end
            end
         end
         ST_DRAIN: begin
            // Wait for the leftmost pixel to merge
            if (!stall) begin
               state_in = ST_ROWEND;
            end
         end
         ST_ROWEND: begin
            // Close the image after the last row, else advance the row
            if (last_row) begin
               if (!stall) begin
                  res_push      = pend_valid_ff;
                  pend_valid_in = 1'b0;
                  pend_len_in   = '0;
                  done_in       = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               row_in   = row_ff + RW'(1);
               state_in = (len_ff != '0) ? ST_FILL : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Read data stays valid while the output side stalls
      dv_in = stall ? dv_ff : ram_re;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         fill_ff       <= '0;
         rd_idx_ff     <= '0;
         row_ff        <= '0;
         pend_color_ff <= '0;
         pend_len_ff   <= '0;
         pend_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
         dv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         fill_ff       <= fill_in;
         rd_idx_ff     <= rd_idx_in;
         row_ff        <= row_in;
         pend_color_ff <= pend_color_in;
         pend_len_ff   <= pend_len_in;
         pend_valid_ff <= pend_valid_in;
         done_ff       <= done_in;
         dv_ff         <= dv_in;
      end
   end

   // Hold the color of the run being expanded
   always_ff @(posedge clock) begin
      color_ff <= color_in;
   end

   rim_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (fill_ff[AW-1:0]),
      .wdata (color_ff),
      .re    (ram_re),
      .raddr (rd_idx_ff),
      .rdata (ram_rdata)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      res_full |-> !res_push)
      else $error("result pushed into a full queue");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("image-done flag dropped without reset");

   a_read_gives_data: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> dv_ff)
      else $error("row read issued but no data valid next cycle");

   a_done_no_open_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !pend_valid_ff)
      else $error("open run left after the image ended");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WW'(MAX_WIDTH - 1))
      else $error("row fill position beyond row RAM");

endmodule

FILE: hdl/rle_image_horizontal_mirror.sv
// Run-length image mirror: an input run is expanded into the row RAM at one
// pixel per cycle after the run is taken from the queue; every completed row is
// then read back right to left through the RAM's single read port at one pixel
// per cycle while the result queue is not full. Mirrored runs merge across rows,
// and a run is emitted when its color changes; the run that closes the last row
// carries last_run, after which input runs are taken and dropped until reset.
// Runs of length zero are discarded on entry. Input and results sit in short
// queues, so the source and the sink may stall independently of the row engine.
// Configuration must be written by the user only while the block is idle; the
// block itself does not enforce this.
// Top level; depends on rim_pkg, rim_front, rim_back, rim_fifo and rim_ram.
module rle_image_horizontal_mirror #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   // input runs
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [rim_pkg::LEN_W-1:0]         req_run_length,
   input  logic [rim_pkg::CHAN_W-1:0]        req_red,
   input  logic [rim_pkg::CHAN_W-1:0]        req_green,
   input  logic [rim_pkg::CHAN_W-1:0]        req_blue,
   // mirrored runs
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [rim_pkg::LEN_W-1:0]         rsp_run_count,
   output logic [rim_pkg::CHAN_W-1:0]        rsp_out_red,
   output logic [rim_pkg::CHAN_W-1:0]        rsp_out_green,
   output logic [rim_pkg::CHAN_W-1:0]        rsp_out_blue,
   output logic                              rsp_last_run,
   // configuration
   input  logic                              csr_we,
   input  logic [rim_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rim_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import rim_pkg::*;

   localparam int RES_DEPTH = 4;

   logic [WIDTH_REG_W-1:0]  image_width_ff;
   logic [HEIGHT_REG_W-1:0] image_height_ff;
   logic                    gray_mode_ff;

   logic                    job_valid, job_pop;
   job_type                 job;
   logic                    res_push, res_full;
   result_type              res, res_out;
   logic [$bits(result_type)-1:0] res_dout;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_REG_W'(64);
         image_height_ff <= HEIGHT_REG_W'(1);
         gray_mode_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
            CSR_GRAY_MODE:    gray_mode_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   rim_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .run_length (req_run_length),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .gray_mode  (gray_mode_ff),
      .job_valid  (job_valid),
      .job        (job),
      .job_pop    (job_pop)
   );

   rim_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .job_valid    (job_valid),
      .job          (job),
      .job_pop      (job_pop),
      .res_push     (res_push),
      .res          (res),
      .res_full     (res_full)
   );

   // Queue results toward the sink
   rim_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RES_DEPTH)
   ) u_res_q (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (res_dout),
      .empty   (rsp_empty)
   );

   assign res_out       = result_type'(res_dout);
   assign rsp_run_count = res_out.count;
   assign rsp_out_red   = res_out.color[3*CHAN_W-1:2*CHAN_W];
   assign rsp_out_green = res_out.color[2*CHAN_W-1:CHAN_W];
   assign rsp_out_blue  = res_out.color[CHAN_W-1:0];
   assign rsp_last_run  = res_out.last;

endmodule

FILE: bench/rle_image_horizontal_mirror_tb.sv
// Self-checking bench for rle_image_horizontal_mirror: pushes input runs, pops mirrored runs
// and checks every one against a row-mirror predictor kept inside the bench.
// Depends on rim_pkg and the rle_image_horizontal_mirror RTL.
module rle_image_horizontal_mirror_tb;
   import rim_pkg::*;

   localparam int ROW_MAX     = 64;
   localparam int ROWS_MAX    = 4096;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int PRINT_LIMIT = 40;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_run_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_push       = 1'b0;
   logic                  req_full;
   logic [LEN_W-1:0]      req_run_length = '0;
   logic [CHAN_W-1:0]     req_red        = '0;
   logic [CHAN_W-1:0]     req_green      = '0;
   logic [CHAN_W-1:0]     req_blue       = '0;
   logic                  rsp_empty;
   logic                  rsp_pop        = 1'b0;
   logic [LEN_W-1:0]      rsp_run_count;
   logic [CHAN_W-1:0]     rsp_out_red;
   logic [CHAN_W-1:0]     rsp_out_green;
   logic [CHAN_W-1:0]     rsp_out_blue;
   logic                  rsp_last_run;
   logic                  csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   // Row mirror state and its copy of the registers
   logic [COLOR_W-1:0] row_pix [ROW_MAX];
   int unsigned        fill_pos     = 0;
   int unsigned        row_idx      = 0;
   logic [COLOR_W-1:0] open_color   = '0;
   logic [LEN_W-1:0]   open_len     = '0;
   bit                 open_valid   = 1'b0;
   bit                 image_closed = 1'b0;
   int unsigned        cfg_width    = 64;
   int unsigned        cfg_height   = 1;
   bit                 cfg_gray     = 1'b0;

   result_type    due_runs[$];
   pixel_run_type pending_runs[$];
   pixel_run_type drive_run;
   int unsigned   runs_queued    = 0;
   int unsigned   runs_taken     = 0;
   int unsigned   work_backlog   = 0;
   int unsigned   send_idle_pct  = 0;
   int unsigned   recv_stall_pct = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count    = 0;

   int unsigned phase_width [8] = '{64, 1, 17, 127, 2, 63, 8, 33};
   bit          phase_gray  [8] = '{0, 1, 0, 1, 1, 0, 0, 1};

   rle_image_horizontal_mirror i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_run_length (req_run_length),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_run_count  (rsp_run_count),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_last_run   (rsp_last_run),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("mismatch: %s", what);
   endtask

   // Row width in use: 0 behaves as 1, anything wider than the RAM as the RAM
   function automatic int unsigned active_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > ROW_MAX) return ROW_MAX;
      return cfg_width;
   endfunction

   task automatic close_run(input logic last_flag);
      due_runs.push_back({open_len, open_color, last_flag});
   endtask

   // Read the row back right to left, merge equal colors, end the image on the last row
   task automatic flush_row(input int unsigned w);
      logic [COLOR_W-1:0] c;
      int unsigned        eff_h;
      eff_h = (cfg_height == 0) ? 1 : ((cfg_height > ROWS_MAX) ? ROWS_MAX : cfg_height);
      for (int i = int'(w) - 1; i >= 0; i--) begin
         c = row_pix[i];
         if (open_valid && c == open_color) begin
            open_len = open_len + LEN_W'(1);
         end else begin
            if (open_valid) close_run(1'b0);
            open_color = c;
            open_len   = LEN_W'(1);
            open_valid = 1'b1;
         end
      end
      fill_pos = 0;
      work_backlog += w + 2;
      if (row_idx + 1 >= eff_h) begin
         if (open_valid) close_run(1'b1);
         open_valid   = 1'b0;
         open_len     = '0;
         image_closed = 1'b1;
      end else begin
         row_idx = (row_idx + 1) % ROWS_MAX;
      end
   endtask

   // Expand one accepted run pixel by pixel into the row
   task automatic mirror_run(input pixel_run_type run);
      logic [COLOR_W-1:0] color;
      int unsigned        left;
      int unsigned        w;
      color = cfg_gray ? {run.red, run.red, run.red} : {run.red, run.green, run.blue};
      left  = 32'(run.len);
      work_backlog++;
      while (left > 0 && !image_closed) begin
         w = active_width();
         row_pix[fill_pos % ROW_MAX] = color;
         fill_pos = (fill_pos + 1) % 128;
         left--;
         work_backlog++;
         if (fill_pos >= w) flush_row(w);
      end
   endtask

   task automatic queue_run(input int unsigned len, input logic [COLOR_W-1:0] color);
      pending_runs.push_back({len[LEN_W-1:0], color});
      runs_queued++;
   endtask

   // Random runs sized to the row width; colors lean on a small palette so runs merge
   task automatic queue_random_runs(input int unsigned count);
      logic [COLOR_W-1:0] palette [4];
      logic [COLOR_W-1:0] color;
      int unsigned        w;
      int unsigned        made;
      int unsigned        pick;
      int unsigned        len;
      w = active_width();
      foreach (palette[i]) palette[i] = COLOR_W'($urandom());
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) len = 0;
         else if (pick < 14) len = $urandom_range(1, 3 * w);
         else if (pick < 54) len = $urandom_range(1, w / 4 + 1);
         else len = $urandom_range(1, w);
         color = ($urandom_range(0, 9) < 6) ? palette[$urandom_range(0, 3)]
                                            : COLOR_W'($urandom());
         queue_run(len, color);
         if (len != 0) made++;
      end
   endtask

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = 59;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 59;
         end
         default: begin
            send_idle_pct  = 7;
            recv_stall_pct = 7;
         end
      endcase
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width  = value % 128;
         CSR_IMAGE_HEIGHT: cfg_height = value % 8192;
         CSR_GRAY_MODE:    cfg_gray   = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every run is taken and every mirrored run is back, then let the engine drain
   task automatic settle();
      while (runs_taken != runs_queued) @(posedge clock);
      while (due_runs.size() != 0) @(posedge clock);
      repeat (work_backlog + 32) @(posedge clock);
      work_backlog = 0;
   endtask

   // Drive input runs from the pending queue; predict each item as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            mirror_run(drive_run);
            runs_taken++;
         end
         if (!req_push || !req_full) begin
            if (pending_runs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drive_run = pending_runs.pop_front();
               req_push       <= 1'b1;
               req_run_length <= drive_run.len;
               req_red        <= drive_run.red;
               req_green      <= drive_run.green;
               req_blue       <= drive_run.blue;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Pop mirrored runs and compare with the oldest expected one
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (due_runs.size() == 0) begin
               note_mismatch($sformatf("unexpected run count %0d color %02h%02h%02h last %0b",
                  rsp_run_count, rsp_out_red, rsp_out_green, rsp_out_blue, rsp_last_run));
            end else begin
               want = due_runs.pop_front();
               if (rsp_run_count !== want.count)
                  note_mismatch($sformatf("run_count %0d, expected %0d",
                     rsp_run_count, want.count));
               if (rsp_out_red !== want.color[23:16])
                  note_mismatch($sformatf("out_red %02h, expected %02h",
                     rsp_out_red, want.color[23:16]));
               if (rsp_out_green !== want.color[15:8])
                  note_mismatch($sformatf("out_green %02h, expected %02h",
                     rsp_out_green, want.color[15:8]));
               if (rsp_out_blue !== want.color[7:0])
                  note_mismatch($sformatf("out_blue %02h, expected %02h",
                     rsp_out_blue, want.color[7:0]));
               if (rsp_last_run !== want.last)
                  note_mismatch($sformatf("last_run %0b, expected %0b",
                     rsp_last_run, want.last));
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rle_image_horizontal_mirror regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Narrow rows: mirroring, merging over row ends, channel extremes, empty run
      set_idle_mode(IDLE_NONE);
      write_csr(CSR_IMAGE_WIDTH, 4);
      write_csr(CSR_IMAGE_HEIGHT, 8191);
      write_csr(CSR_GRAY_MODE, 0);
      queue_run(0, 24'hFFFFFF);
      queue_run(1, 24'h000000);
      queue_run(1, 24'hFFFFFF);
      queue_run(2, 24'hFF0000);
      queue_run(6, 24'h000000);
      queue_run(3, 24'h00FF00);
      queue_run(1, 24'h0000FF);
      queue_run(2, 24'h807F01);
      queue_run(3, 24'h00FFFF);
      settle();

      // Width 0 acts as 1 and shrinks the row under the pixels already held
      set_idle_mode(IDLE_SENDER);
      write_csr(CSR_IMAGE_WIDTH, 0);
      queue_run(1, 24'h123456);
      queue_run(3, 24'h123456);
      queue_run(2, 24'h654321);
      settle();

      // Oversized width clamps to full rows; gray mode ignores green and blue
      set_idle_mode(IDLE_RECEIVER);
      write_csr(CSR_IMAGE_WIDTH, 127);
      write_csr(CSR_GRAY_MODE, 1);
      queue_run(5, 24'h10ABCD);
      queue_run(70, 24'h20FF00);
      queue_run(1, 24'h2000FF);
      queue_run(0, 24'h000000);
      queue_run(64, 24'hFFFFFF);
      queue_run(1, 24'h00FFFF);
      settle();

      // Random phases over a spread of widths, gray settings and idle patterns
      for (int ph = 0; ph < 8; ph++) begin
         set_idle_mode(idle_mode_type'(ph % 4));
         write_csr(CSR_IMAGE_WIDTH, phase_width[ph]);
         write_csr(CSR_GRAY_MODE, 32'(phase_gray[ph]));
         if (ph == 3) write_csr(CSR_IMAGE_HEIGHT, ROWS_MAX);
         queue_random_runs(48);
         settle();
      end

      // Height 0 ends the image at the next row end; later runs are dropped
      set_idle_mode(IDLE_BOTH);
      write_csr(CSR_IMAGE_HEIGHT, 0);
      queue_random_runs(10);
      queue_run(2 ** LEN_W - 1, COLOR_W'($urandom()));
      settle();

      if (mismatch_count == 0) begin
         $display("rle_image_horizontal_mirror regression: pass");
      end else begin
         $display("rle_image_horizontal_mirror regression: fail");
      end
      $finish;
   end

endmodule
